// File: src/tdsplit_pkg.sv
// ----------------------------------------------------------------------------
// tdsplit_pkg
// Types and constants shared by the template delimiter splitter.
// ----------------------------------------------------------------------------
package tdsplit_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned ODATA_W = 16;
	localparam int unsigned OUSER_W = 3;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = 2;
	localparam int unsigned QCNT_W  = 3;

	localparam logic [CIDX_W-1:0] REG_SINGLE_OPEN       = 3'd0;
	localparam logic [CIDX_W-1:0] REG_SINGLE_CLOSE      = 3'd1;
	localparam logic [CIDX_W-1:0] REG_PAIR_OPEN_FIRST   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_PAIR_OPEN_SECOND  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_PAIR_CLOSE_FIRST  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_PAIR_CLOSE_SECOND = 3'd5;

	typedef enum logic [1:0] {
		KIND_STATIC  = 2'd0,
		KIND_DYNAMIC = 2'd1,
		KIND_NONE    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_STATIC = 2'd0,
		MODE_SINGLE = 2'd1,
		MODE_PAIR   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		kind_t             segment_kind;
		logic              segment_end;
		logic              stream_end;
	} result_t;

endpackage

// File: src/template_delimiter_splitter.sv
// ----------------------------------------------------------------------------
// template_delimiter_splitter
// Splits a template byte stream into static and dynamic segments.
// ----------------------------------------------------------------------------
// Results are registered in the result queue before they appear on m_tvalid.
// Throughput: one byte per cycle while s_tready is high, i.e. while the queue
// holds two results or fewer; a byte that yields two results is absorbed by a four-entry result queue.
// Reset: arst_n clears delimiter registers, segment state and the queue.
module template_delimiter_splitter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tdsplit_pkg::BYTE_W-1:0]      s_tdata,  // [7:0] in_byte
	input  logic                                s_tlast,  // end_of_input
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tdsplit_pkg::ODATA_W-1:0]     m_tdata,  // [7:0] out_byte, [8] stream_end
	output logic [tdsplit_pkg::OUSER_W-1:0]     m_tuser,  // [0] has_byte, [2:1] segment_kind
	output logic                                m_tlast,  // segment_end
	input  logic                                cfg_we,
	input  logic [tdsplit_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [tdsplit_pkg::BYTE_W-1:0]      cfg_data
);

	logic [tdsplit_pkg::BYTE_W-1:0] single_open_q, single_close_q;
	logic [tdsplit_pkg::BYTE_W-1:0] pair_open_first_q, pair_open_second_q;
	logic [tdsplit_pkg::BYTE_W-1:0] pair_close_first_q, pair_close_second_q;

	tdsplit_pkg::mode_t             mode_q, mode_d;
	logic                           held_q, held_d;
	logic                           started_q, started_d;
	logic [tdsplit_pkg::BYTE_W-1:0] held_val_q, held_val_d;

	tdsplit_pkg::result_t           res0, res1;
	logic [1:0]                     nres;

	tdsplit_pkg::result_t           queue_q [tdsplit_pkg::QDEPTH];
	logic [tdsplit_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [tdsplit_pkg::QCNT_W-1:0] count_q;

	logic                           in_xfer, out_xfer;
	logic [tdsplit_pkg::BYTE_W-1:0] c;
	logic                           eoi;
	logic                           dyn;
	tdsplit_pkg::kind_t             kind;
	logic [tdsplit_pkg::BYTE_W-1:0] second;
	tdsplit_pkg::result_t           head;

	assign c        = s_tdata;
	assign eoi      = s_tlast;
	assign s_tready = (count_q <= tdsplit_pkg::QCNT_W'(2));
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = (count_q != '0);
	assign out_xfer = m_tvalid && m_tready;
	assign dyn      = (mode_q == tdsplit_pkg::MODE_SINGLE) || (mode_q == tdsplit_pkg::MODE_PAIR);
	assign kind     = dyn ? tdsplit_pkg::KIND_DYNAMIC : tdsplit_pkg::KIND_STATIC;
	assign second   = (mode_q == tdsplit_pkg::MODE_PAIR) ? pair_close_second_q
	                                                     : pair_open_second_q;

	function automatic tdsplit_pkg::result_t mk_res(
		input logic [tdsplit_pkg::BYTE_W-1:0] b,
		input logic                           hb,
		input tdsplit_pkg::kind_t             k,
		input logic                           se,
		input logic                           st
	);
		tdsplit_pkg::result_t r;
		r.out_byte     = b;
		r.has_byte     = hb;
		r.segment_kind = k;
		r.segment_end  = se;
		r.stream_end   = st;
		return r;
	endfunction

	always_comb begin
		mode_d     = mode_q;
		held_d     = held_q;
		started_d  = started_q;
		held_val_d = held_val_q;
		res0       = mk_res('0, 1'b0, tdsplit_pkg::KIND_STATIC, 1'b0, 1'b0);
		res1       = res0;
		nres       = 2'd0;
		if (eoi) begin
			if (held_q) begin
				res0 = mk_res(held_val_q, 1'b1, kind, 1'b0, 1'b0);
				res1 = mk_res('0, 1'b0, kind, 1'b1, 1'b1);
				nres = 2'd2;
			end else begin
				res0 = mk_res('0, 1'b0,
					(!dyn && !started_q) ? tdsplit_pkg::KIND_NONE : kind, 1'b1, 1'b1);
				nres = 2'd1;
			end
			mode_d     = tdsplit_pkg::MODE_STATIC;
			held_d     = 1'b0;
			started_d  = 1'b0;
			held_val_d = '0;
		end else if (mode_q == tdsplit_pkg::MODE_SINGLE) begin
			nres = 2'd1;
			if (c != '0 && c == single_close_q) begin
				res0      = mk_res('0, 1'b0, tdsplit_pkg::KIND_DYNAMIC, 1'b1, 1'b0);
				mode_d    = tdsplit_pkg::MODE_STATIC;
				started_d = 1'b0;
			end else begin
				res0 = mk_res(c, 1'b1, tdsplit_pkg::KIND_DYNAMIC, 1'b0, 1'b0);
			end
		end else if (held_q) begin
			held_d = 1'b0;
			if (c == second) begin
				res0      = mk_res('0, 1'b0, kind, 1'b1, 1'b0);
				nres      = 2'd1;
				mode_d    = (mode_q == tdsplit_pkg::MODE_PAIR) ? tdsplit_pkg::MODE_STATIC
				                                               : tdsplit_pkg::MODE_PAIR;
				started_d = 1'b0;
			end else begin
				res0 = mk_res(held_val_q, 1'b1, kind, 1'b0, 1'b0);
				res1 = mk_res(c, 1'b1, kind, 1'b0, 1'b0);
				nres = 2'd2;
			end
		end else if (mode_q == tdsplit_pkg::MODE_PAIR) begin
			if (c != '0 && c == pair_close_first_q) begin
				held_d     = 1'b1;
				held_val_d = c;
			end else begin
				res0 = mk_res(c, 1'b1, tdsplit_pkg::KIND_DYNAMIC, 1'b0, 1'b0);
				nres = 2'd1;
			end
		end else begin
			mode_d    = tdsplit_pkg::MODE_STATIC;
			started_d = 1'b1;
			if (c != '0 && c == single_open_q) begin
				res0      = mk_res('0, 1'b0, tdsplit_pkg::KIND_STATIC, 1'b1, 1'b0);
				nres      = 2'd1;
				mode_d    = tdsplit_pkg::MODE_SINGLE;
				started_d = 1'b0;
			end else if (c != '0 && c == pair_open_first_q) begin
				held_d     = 1'b1;
				held_val_d = c;
			end else begin
				res0 = mk_res(c, 1'b1, tdsplit_pkg::KIND_STATIC, 1'b0, 1'b0);
				nres = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_open_q       <= '0;
			single_close_q      <= '0;
			pair_open_first_q   <= '0;
			pair_open_second_q  <= '0;
			pair_close_first_q  <= '0;
			pair_close_second_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdsplit_pkg::REG_SINGLE_OPEN:       single_open_q       <= cfg_data;
				tdsplit_pkg::REG_SINGLE_CLOSE:      single_close_q      <= cfg_data;
				tdsplit_pkg::REG_PAIR_OPEN_FIRST:   pair_open_first_q   <= cfg_data;
				tdsplit_pkg::REG_PAIR_OPEN_SECOND:  pair_open_second_q  <= cfg_data;
				tdsplit_pkg::REG_PAIR_CLOSE_FIRST:  pair_close_first_q  <= cfg_data;
				tdsplit_pkg::REG_PAIR_CLOSE_SECOND: pair_close_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= tdsplit_pkg::MODE_STATIC;
			held_q     <= 1'b0;
			started_q  <= 1'b0;
			held_val_q <= '0;
		end else if (in_xfer) begin
			mode_q     <= mode_d;
			held_q     <= held_d;
			started_q  <= started_d;
			held_val_q <= held_val_d;
		end
	end

	// result queue
	assign wr_ptr_nx = wr_ptr_q + tdsplit_pkg::QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (in_xfer && nres != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (in_xfer && nres == 2'd2) begin
			queue_q[wr_ptr_nx] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_xfer) begin
				wr_ptr_q <= wr_ptr_q + tdsplit_pkg::QPTR_W'(nres);
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + tdsplit_pkg::QPTR_W'(1);
			end
			count_q <= count_q
				+ (in_xfer ? tdsplit_pkg::QCNT_W'(nres) : '0)
				- (out_xfer ? tdsplit_pkg::QCNT_W'(1) : '0);
		end
	end

	assign head    = queue_q[rd_ptr_q];
	assign m_tdata = {{(tdsplit_pkg::ODATA_W-tdsplit_pkg::BYTE_W-1){1'b0}},
	                  head.stream_end, head.out_byte};
	assign m_tuser = {head.segment_kind, head.has_byte};
	assign m_tlast = head.segment_end;

endmodule
